@@ sv/cle_pkg.sv @@
package cle_pkg;

	// request codes
	localparam logic [2:0] REQ_PUSH     = 3'd0;
	localparam logic [2:0] REQ_POP      = 3'd1;
	localparam logic [2:0] REQ_CONTAINS = 3'd2;
	localparam logic [2:0] REQ_REMOVE   = 3'd3;
	localparam logic [2:0] REQ_ERASE    = 3'd4;
	localparam logic [2:0] REQ_READ     = 3'd5;
	localparam logic [2:0] REQ_WRITE    = 3'd6;

	// status codes
	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_FULL     = 3'd1;
	localparam logic [2:0] STS_EMPTY    = 3'd2;
	localparam logic [2:0] STS_NOTFOUND = 3'd3;
	localparam logic [2:0] STS_RANGE    = 3'd4;

	localparam int WORD_W  = 32;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	typedef logic [WORD_W-1:0] word_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic cmp;    // latch compare against incoming value
		logic load;   // take load_value
		logic shift;  // take the upper neighbor's word
	} cell_ctl_t;

endpackage

@@ sv/cle_cell.sv @@
module cle_cell (
	input  logic              clk,
	input  cle_pkg::cell_ctl_t ctl,
	input  cle_pkg::word_t    load_value,
	input  cle_pkg::word_t    next_value,
	input  cle_pkg::word_t    cmp_value,
	output cle_pkg::word_t    value,
	output logic              hit
);

	cle_pkg::word_t data_q;
	logic           hit_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			hit_q <= (data_q == cmp_value);
		end
		if (ctl.load) begin
			data_q <= load_value;
		end else if (ctl.shift) begin
			data_q <= next_value;
		end
	end

	assign value = data_q;
	assign hit   = hit_q;

endmodule

@@ sv/compacting_list_engine_core.sv @@
// Bounded ordered list of signed 32-bit words, one word per cell in a row of cells.
// A request transfers in and every cell latches its compare at the transfer edge; the
// first-match prefix, shift/load and result capture follow in the execute state, which
// waits while the output register is full and not drained. A new request is taken only
// once the previous one has finished its compare-then-update pass over the row.
// Reset (arst_n low, asynchronous): fill count, sequencer and output valid clear; cell
// words are not reset and hold no meaning until written.
module compacting_list_engine_core #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] item_value,
	input  logic [3:0]         position,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] data_out,
	output logic               found,
	output logic [4:0]         entries
);

	// fill count wide enough to hold CAPACITY itself
	localparam int FW = $clog2(CAPACITY + 1);
	// compare width covering both the fill count and the position field
	localparam int CW = (FW > cle_pkg::POS_W) ? FW : cle_pkg::POS_W;

	// sequencer codes
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic            state_q;
	logic [FW-1:0]   fill_q;

	// request held across the compare cycle
	logic [2:0]      req_q;
	cle_pkg::word_t  val_q;
	logic [3:0]      pos_q;

	// output register
	logic            out_valid_q;
	logic [2:0]      status_q;
	cle_pkg::word_t  data_q;
	logic            found_q;
	logic [4:0]      entries_q;

	logic in_xfer;
	logic exec_go;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	// finish only when the output register is free or being drained
	assign exec_go  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	// ---------------------------------------------------------------------
	// row of cells
	// ---------------------------------------------------------------------
	cle_pkg::word_t      cell_val [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;
	logic [CAPACITY-1:0] hit_v;     // hit on an occupied cell
	logic [CAPACITY-1:0] pre_v;     // first-match prefix: at or past the first hit
	logic [CAPACITY-1:0] load_v;
	cle_pkg::word_t      rd_acc [CAPACITY+1];

	logic [CW-1:0] fill_ext;
	logic [CW-1:0] pos_ext;
	logic          pos_bad;

	assign fill_ext = CW'(fill_q);
	assign pos_ext  = CW'(pos_q);
	assign pos_bad  = (pos_ext >= fill_ext);

	// decoded operation, qualified by its error checks
	logic do_push, do_write, do_erase, do_remove, do_pop, do_read;

	assign rd_acc[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cle_pkg::cell_ctl_t ctl;
		cle_pkg::word_t     nxt;
		logic               occupied;
		logic               sel_rd;

		assign occupied = (CW'(i) < fill_ext);
		assign hit_v[i] = cell_hit[i] && occupied;

		if (i == 0) begin : g_first
			assign pre_v[i] = hit_v[i];
		end else begin : g_rest
			assign pre_v[i] = pre_v[i-1] || hit_v[i];
		end

		// top cell has no neighbor above; its word past fill is don't-care
		if (i == CAPACITY - 1) begin : g_top
			assign nxt = cell_val[i];
		end else begin : g_mid
			assign nxt = cell_val[i+1];
		end

		assign ctl.cmp   = in_xfer;
		assign ctl.load  = exec_go &&
			((do_push && (CW'(i) == fill_ext)) || (do_write && (CW'(i) == pos_ext)));
		assign ctl.shift = exec_go &&
			((do_remove && pre_v[i]) || (do_erase && (CW'(i) >= pos_ext)));
		assign load_v[i] = ctl.load;

		// pop takes the last occupied cell, read takes the addressed one
		assign sel_rd = (do_pop && (CW'(i + 1) == fill_ext)) ||
			(do_read && (CW'(i) == pos_ext));
		assign rd_acc[i+1] = rd_acc[i] | (sel_rd ? cell_val[i] : '0);

		cle_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.load_value (val_q),
			.next_value (nxt),
			.cmp_value  (cle_pkg::word_t'(item_value)),
			.value      (cell_val[i]),
			.hit        (cell_hit[i])
		);
	end

	// ---------------------------------------------------------------------
	// result and fill update
	// ---------------------------------------------------------------------
	logic [2:0]    res_status;
	logic          res_found;
	logic [FW-1:0] fill_nxt;
	logic          any_hit;

	assign any_hit = pre_v[CAPACITY-1];

	always_comb begin
		res_status = cle_pkg::STS_OK;
		res_found  = 1'b0;
		fill_nxt   = fill_q;
		do_push    = 1'b0;
		do_pop     = 1'b0;
		do_remove  = 1'b0;
		do_erase   = 1'b0;
		do_read    = 1'b0;
		do_write   = 1'b0;
		case (req_q)
			cle_pkg::REQ_PUSH: begin
				if (fill_q == FW'(CAPACITY)) begin
					res_status = cle_pkg::STS_FULL;
				end else begin
					do_push  = 1'b1;
					fill_nxt = fill_q + FW'(1);
				end
			end
			cle_pkg::REQ_POP: begin
				if (fill_q == '0) begin
					res_status = cle_pkg::STS_EMPTY;
				end else begin
					do_pop   = 1'b1;
					fill_nxt = fill_q - FW'(1);
				end
			end
			cle_pkg::REQ_CONTAINS: begin
				res_found = any_hit;
			end
			cle_pkg::REQ_REMOVE: begin
				if (any_hit) begin
					do_remove = 1'b1;
					fill_nxt  = fill_q - FW'(1);
				end else begin
					res_status = cle_pkg::STS_NOTFOUND;
				end
			end
			cle_pkg::REQ_ERASE: begin
				if (pos_bad) begin
					res_status = cle_pkg::STS_RANGE;
				end else begin
					do_erase = 1'b1;
					fill_nxt = fill_q - FW'(1);
				end
			end
			cle_pkg::REQ_READ: begin
				if (pos_bad) begin
					res_status = cle_pkg::STS_RANGE;
				end else begin
					do_read = 1'b1;
				end
			end
			cle_pkg::REQ_WRITE: begin
				if (pos_bad) begin
					res_status = cle_pkg::STS_RANGE;
				end else begin
					do_write = 1'b1;
				end
			end
			default: begin
				// unused code: plain ok, nothing touched
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// sequencer and registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_go) begin
				fill_q      <= fill_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q <= req_type;
			val_q <= cle_pkg::word_t'(item_value);
			pos_q <= position;
		end
		if (exec_go) begin
			status_q  <= res_status;
			data_q    <= rd_acc[CAPACITY];
			found_q   <= res_found;
			entries_q <= 5'(fill_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_q;
	assign found     = found_q;
	assign entries   = entries_q;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CAPACITY))
		else $error("fill count above capacity");

	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(load_v))
		else $error("more than one cell loaded");

	a_fill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_go |=> $stable(fill_q))
		else $error("fill count moved outside a request");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> out_valid_q)
		else $error("finished request produced no result");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_EXEC))
		else $error("accepted request not executed");

endmodule

@@ tb/sv/tb_compacting_list_engine_core.sv @@
`timescale 1ns / 100ps

module tb_compacting_list_engine_core;

	localparam int LIST_DEPTH = 16;
	// receiver hold-off, long enough to back the block up into its input
	localparam int RX_HOLD_CYCLES = 200;

	typedef struct {
		logic [2:0]         status;
		logic signed [31:0] data_out;
		logic               found;
		logic [4:0]         entries;
	} list_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         req_type;
	logic signed [31:0] item_value;
	logic [3:0]         position;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic signed [31:0] data_out;
	logic               found;
	logic [4:0]         entries;

	// shadow copy of the list, updated in transfer order
	cle_pkg::word_t shadow_slots [LIST_DEPTH];
	int             shadow_fill;
	list_result_t   pending_results[$];
	list_result_t   oldest_result;
	int             fail_count;

	// traffic shaping
	logic         calm;         // no random idling on either side while set; a receiver hold-off still applies
	logic [7:0]   hold_token;   // bumped by a test to start a receiver hold-off
	logic [7:0]   hold_seen;
	int           hold_left;

	compacting_list_engine_core #(
		.CAPACITY(LIST_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.item_value(item_value),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.data_out(data_out),
		.found(found),
		.entries(entries)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Shift every entry above the hole down by one and drop the count.
	function automatic void shadow_close_gap(input int at);
		for (int i = at; i + 1 < shadow_fill; i++)
			shadow_slots[i] = shadow_slots[i + 1];
		shadow_fill--;
	endfunction

	// Apply one request to the shadow list and return the result it must produce.
	function automatic list_result_t apply_list_request(input logic [2:0] kind,
			input cle_pkg::word_t val, input logic [3:0] pos);
		list_result_t r;
		int           hit_at;
		r.status   = cle_pkg::STS_OK;
		r.data_out = '0;
		r.found    = 1'b0;
		hit_at     = -1;
		case (kind)
			cle_pkg::REQ_PUSH: begin
				if (shadow_fill >= LIST_DEPTH) begin
					r.status = cle_pkg::STS_FULL;
				end else begin
					shadow_slots[shadow_fill] = val;
					shadow_fill++;
				end
			end
			cle_pkg::REQ_POP: begin
				if (shadow_fill == 0) begin
					r.status = cle_pkg::STS_EMPTY;
				end else begin
					shadow_fill--;
					r.data_out = shadow_slots[shadow_fill];
				end
			end
			cle_pkg::REQ_CONTAINS, cle_pkg::REQ_REMOVE: begin
				for (int i = 0; i < shadow_fill; i++)
					if (hit_at < 0 && shadow_slots[i] == val)
						hit_at = i;
				if (kind == cle_pkg::REQ_CONTAINS)
					r.found = (hit_at >= 0);
				else if (hit_at < 0)
					r.status = cle_pkg::STS_NOTFOUND;
				else
					shadow_close_gap(hit_at);
			end
			cle_pkg::REQ_ERASE, cle_pkg::REQ_READ, cle_pkg::REQ_WRITE: begin
				if (int'(pos) >= shadow_fill)
					r.status = cle_pkg::STS_RANGE;
				else if (kind == cle_pkg::REQ_ERASE)
					shadow_close_gap(int'(pos));
				else if (kind == cle_pkg::REQ_READ)
					r.data_out = shadow_slots[pos];
				else
					shadow_slots[pos] = val;
			end
			default: ;
		endcase
		r.entries = shadow_fill[4:0];
		return r;
	endfunction

	// Half of the picks are values already in the list or a small pool, so searches hit
	// and duplicates show up; the rest are extremes and full-range words.
	function automatic cle_pkg::word_t pick_value();
		case ($urandom_range(9))
			0, 1, 2: return (shadow_fill > 0) ?
				shadow_slots[$urandom_range(shadow_fill - 1)] :
				cle_pkg::word_t'($urandom_range(7));
			3, 4: return cle_pkg::word_t'($urandom_range(7));
			5: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return cle_pkg::word_t'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_position();
		if (shadow_fill > 0 && $urandom_range(99) < 80)
			return 4'($urandom_range(shadow_fill - 1));
		return 4'($urandom_range(15));
	endfunction

	// One request transfer. Called at a rising edge; returns at the edge where
	// the request was taken, leaving in_valid high so the next call can follow
	// back to back.
	task automatic send_req(input logic [2:0] kind, input cle_pkg::word_t val,
			input logic [3:0] pos);
		if (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		item_value <= val;
		position   <= pos;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(apply_list_request(kind, val, pos));
	endtask

	// Stop offering until every outstanding result has come back.
	task automatic wait_list_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic run_random_ops(input int count, input int push_pct);
		logic [2:0] kind;
		repeat (count) begin
			if ($urandom_range(99) < push_pct)
				kind = cle_pkg::REQ_PUSH;
			else
				kind = 3'($urandom_range(6, 1));
			send_req(kind, pick_value(), pick_position());
		end
	endtask

	// Empty-list errors, extreme values, every request kind, duplicate removal,
	// positions at and past the count.
	task automatic test_directed_cases();
		send_req(cle_pkg::REQ_POP,      32'h0000_0000, 4'd0);
		send_req(cle_pkg::REQ_REMOVE,   32'h0000_0005, 4'd0);
		send_req(cle_pkg::REQ_CONTAINS, 32'h0000_0000, 4'd0);
		send_req(cle_pkg::REQ_READ,     32'h0000_0000, 4'd0);
		send_req(cle_pkg::REQ_ERASE,    32'h0000_0000, 4'd0);
		send_req(cle_pkg::REQ_WRITE,    32'h1234_5678, 4'd15);
		send_req(cle_pkg::REQ_PUSH,     32'h8000_0000, 4'd0);
		send_req(cle_pkg::REQ_PUSH,     32'h7FFF_FFFF, 4'd0);
		send_req(cle_pkg::REQ_PUSH,     32'h0000_0000, 4'd0);
		send_req(cle_pkg::REQ_PUSH,     32'hFFFF_FFFF, 4'd0);
		send_req(cle_pkg::REQ_PUSH,     32'h0000_0005, 4'd0);
		send_req(cle_pkg::REQ_PUSH,     32'h0000_0005, 4'd0);
		send_req(cle_pkg::REQ_CONTAINS, 32'h7FFF_FFFF, 4'd0);
		send_req(cle_pkg::REQ_CONTAINS, 32'h0000_1234, 4'd0);
		send_req(cle_pkg::REQ_READ,     32'h0000_0000, 4'd1);
		send_req(cle_pkg::REQ_READ,     32'h0000_0000, 4'd15);
		send_req(cle_pkg::REQ_WRITE,    32'hA5A5_A5A5, 4'd2);
		// first of two equal entries goes, the other slides down
		send_req(cle_pkg::REQ_REMOVE,   32'h0000_0005, 4'd0);
		send_req(cle_pkg::REQ_REMOVE,   32'h0000_0063, 4'd0);
		send_req(cle_pkg::REQ_ERASE,    32'h0000_0000, 4'd0);
		send_req(cle_pkg::REQ_ERASE,    32'h0000_0000, 4'd4);
		send_req(cle_pkg::REQ_WRITE,    32'h5A5A_5A5A, 4'd4);
		send_req(cle_pkg::REQ_POP,      32'h0000_0000, 4'd0);
		send_req(cle_pkg::REQ_READ,     32'h0000_0000, 4'd3);
	endtask

	// Push-heavy run to hit the full list, then a drain-heavy run to empty it.
	task automatic test_grow_and_shrink();
		run_random_ops(250, 70);
		run_random_ops(250, 8);
	endtask

	task automatic test_back_to_back(input int count);
		calm = 1'b1;
		run_random_ops(count, 35);
		calm = 1'b0;
	endtask

	// Receiver holds off while requests keep coming, so the block backs up
	// and stalls its input; then the sender waits for everything to drain.
	task automatic test_output_hold();
		calm = 1'b1;
		hold_token <= hold_token + 8'd1;
		run_random_ops(40, 40);
		wait_list_idle();
		calm = 1'b0;
	endtask

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing outstanding: status %0d data_out %0d",
					status, data_out);
				fail_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (status !== oldest_result.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						oldest_result.status, status);
					fail_count++;
				end
				if (data_out !== oldest_result.data_out) begin
					$error("data_out mismatch: expected %0d, actual %0d",
						oldest_result.data_out, data_out);
					fail_count++;
				end
				if (found !== oldest_result.found) begin
					$error("found mismatch: expected %0d, actual %0d",
						oldest_result.found, found);
					fail_count++;
				end
				if (entries !== oldest_result.entries) begin
					$error("entries mismatch: expected %0d, actual %0d",
						oldest_result.entries, entries);
					fail_count++;
				end
			end
		end
	end

	// Receiver ready pattern, with the hold-off counted here.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= RX_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 13);
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		req_type    = cle_pkg::REQ_PUSH;
		item_value  = '0;
		position    = '0;
		out_ready   = 1'b0;
		calm        = 1'b0;
		hold_token  = '0;
		hold_seen   = '0;
		hold_left   = 0;
		fail_count  = 0;
		shadow_fill = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		run_random_ops(500, 30);
		test_grow_and_shrink();
		test_back_to_back(400);
		test_output_hold();
		run_random_ops(400, 25);

		wait_list_idle();
		// catch any stray result after the last one was due
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("compacting_list_engine_core regression: pass");
		else
			$display("compacting_list_engine_core regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("compacting_list_engine_core regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
sv/cle_pkg.sv
sv/cle_cell.sv
sv/compacting_list_engine_core.sv
tb/sv/tb_compacting_list_engine_core.sv
